FILE: rtl/ple_pkg.sv
package ple_pkg;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_SET    = 3'd2,
    KIND_GET    = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  localparam int IN_VALUE_W  = 32;
  localparam int OUT_VALUE_W = 32;
  // wide enough to sign-extend the input value to a storage width of up to 96 bits
  localparam int EXT_W       = 96;

endpackage

FILE: rtl/positional_list_engine_top.sv
// Set, clear, unused kinds and refused operations go from accept straight to S_FIN.
// Get passes through S_GET; insert walks S_UP and then S_INS_WR when it shifts.
// Remove walks S_DN when it shifts; one RAM entry moves per cycle.
// in_ready is high only while idle, so a new item waits until the last result is loaded.
// Synchronous active-low reset empties the list; RAM contents are not cleared.
module positional_list_engine_top #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [2:0]                                 in_kind,
  input  logic [$clog2(CAPACITY+1)-1:0]              in_position,
  input  logic signed [ple_pkg::IN_VALUE_W-1:0]      in_value,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic signed [ple_pkg::OUT_VALUE_W-1:0]     out_read_value,
  output logic [1:0]                                 out_status,
  output logic [$clog2(CAPACITY+1)-1:0]              out_count,
  output logic                                       out_is_empty
);

  localparam int POS_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_UP     = 6'b000010,
    S_INS_WR = 6'b000100,
    S_DN     = 6'b001000,
    S_GET    = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [POS_W-1:0]             count_r, count_nxt;
  logic [ADDR_W-1:0]            ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]            dst_r, dst_nxt;
  logic [ADDR_W-1:0]            pos_r, pos_nxt;
  logic [VALUE_WIDTH-1:0]       val_r, val_nxt;
  logic [ple_pkg::OUT_VALUE_W-1:0] res_rd_r, res_rd_nxt;
  ple_pkg::status_t             res_status_r, res_status_nxt;

  logic                         out_valid_r;
  logic [ple_pkg::OUT_VALUE_W-1:0] out_rd_r;
  ple_pkg::status_t             out_status_r;
  logic [POS_W-1:0]             out_count_r;

  logic [ple_pkg::EXT_W-1:0]    in_ext;
  logic [ple_pkg::EXT_W-1:0]    rd_ext;
  logic [VALUE_WIDTH-1:0]       in_val_w;
  ple_pkg::kind_t               kind_w;
  logic                         accept;
  logic                         load_out;

  // shared index unit
  logic [POS_W-1:0]             step_opnd;
  logic                         step_dec;
  logic [POS_W-1:0]             step_sum;

  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [VALUE_WIDTH-1:0]       ram_wdata;
  logic [ADDR_W-1:0]            ram_raddr;
  logic [VALUE_WIDTH-1:0]       ram_rdata;

  assign in_ext   = {{(ple_pkg::EXT_W - ple_pkg::IN_VALUE_W){in_value[ple_pkg::IN_VALUE_W-1]}},
                     in_value};
  assign in_val_w = in_ext[VALUE_WIDTH-1:0];
  assign rd_ext   = {{(ple_pkg::EXT_W - VALUE_WIDTH){1'b0}}, ram_rdata};
  assign kind_w   = ple_pkg::kind_t'(in_kind);

  assign in_ready = state_r[0];
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    step_dec  = (state_r == S_UP) || ((state_r == S_IDLE) && (kind_w == ple_pkg::KIND_INSERT));
    step_opnd = POS_W'(ptr_r);
    if (state_r == S_IDLE) begin
      step_opnd = (kind_w == ple_pkg::KIND_INSERT) ? count_r : in_position;
    end
    step_sum = step_dec ? step_opnd - POS_W'(1) : step_opnd + POS_W'(1);
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    dst_nxt        = dst_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    res_rd_nxt     = res_rd_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    ram_waddr      = dst_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = step_sum[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_rd_nxt     = '0;
          res_status_nxt = ple_pkg::ST_OK;
          state_nxt      = S_FIN;
          pos_nxt        = in_position[ADDR_W-1:0];
          val_nxt        = in_val_w;
          case (kind_w)
            ple_pkg::KIND_INSERT: begin
              if (in_position > count_r) begin
                // bad position: no change, result reported with ST_OK
              end else if (count_r == POS_W'(CAPACITY)) begin
                res_status_nxt = ple_pkg::ST_FULL;
              end else if (in_position == count_r) begin
                ram_we    = 1'b1;
                ram_waddr = in_position[ADDR_W-1:0];
                ram_wdata = in_val_w;
                count_nxt = count_r + POS_W'(1);
              end else begin
                ptr_nxt   = step_sum[ADDR_W-1:0];
                dst_nxt   = count_r[ADDR_W-1:0];
                state_nxt = S_UP;
              end
            end
            ple_pkg::KIND_REMOVE: begin
              if (in_position < count_r) begin
                if (step_sum == count_r) begin
                  count_nxt = count_r - POS_W'(1);
                end else begin
                  ptr_nxt   = step_sum[ADDR_W-1:0];
                  dst_nxt   = in_position[ADDR_W-1:0];
                  state_nxt = S_DN;
                end
              end
            end
            ple_pkg::KIND_SET: begin
              if (in_position < count_r) begin
                ram_we    = 1'b1;
                ram_waddr = in_position[ADDR_W-1:0];
                ram_wdata = in_val_w;
              end else begin
                res_status_nxt = ple_pkg::ST_BAD_POS;
              end
            end
            ple_pkg::KIND_GET: begin
              ram_raddr = in_position[ADDR_W-1:0];
              if (in_position < count_r) begin
                state_nxt = S_GET;
              end else begin
                res_status_nxt = ple_pkg::ST_BAD_POS;
              end
            end
            ple_pkg::KIND_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_UP: begin
        // move the entry read last cycle one slot up
        ram_we = 1'b1;
        if (ptr_r == pos_r) begin
          state_nxt = S_INS_WR;
        end else begin
          ptr_nxt = step_sum[ADDR_W-1:0];
          dst_nxt = ptr_r;
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = val_r;
        count_nxt = count_r + POS_W'(1);
        state_nxt = S_FIN;
      end
      S_DN: begin
        // move the entry read last cycle one slot down
        ram_we = 1'b1;
        if (step_sum == count_r) begin
          count_nxt = count_r - POS_W'(1);
          state_nxt = S_FIN;
        end else begin
          ptr_nxt = step_sum[ADDR_W-1:0];
          dst_nxt = ptr_r;
        end
      end
      S_GET: begin
        res_rd_nxt = rd_ext[ple_pkg::OUT_VALUE_W-1:0];
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    dst_r        <= dst_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    res_rd_r     <= res_rd_nxt;
    res_status_r <= res_status_nxt;
    if (load_out) begin
      out_rd_r     <= res_rd_r;
      out_status_r <= res_status_r;
      out_count_r  <= count_r;
    end
  end

  ple_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rd_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;
  assign out_is_empty   = (out_count_r == '0);

endmodule

FILE: rtl/ple_ram.sv
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/ple_checker.sv
module ple_checker #(
  parameter int CAPACITY = 64
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic [ple_pkg::OUT_VALUE_W-1:0]        out_read_value,
  input logic [1:0]                             out_status,
  input logic [$clog2(CAPACITY+1)-1:0]          out_count,
  input logic                                   out_is_empty
);

  localparam int POS_W = $clog2(CAPACITY + 1);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value)
      && $stable(out_status) && $stable(out_count))
    else $error("stalled result changed");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == '0)))
    else $error("is_empty disagrees with count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= POS_W'(CAPACITY)))
    else $error("count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ple_pkg::ST_FULL) |-> (out_count == POS_W'(CAPACITY)))
    else $error("full status with room left");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ple_pkg::ST_OK) |-> (out_read_value == '0))
    else $error("read data on a flagged result");

endmodule

bind positional_list_engine_top ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_value (out_read_value),
  .out_status     (out_status),
  .out_count      (out_count),
  .out_is_empty   (out_is_empty)
);

FILE: sim/positional_list_engine_top_tb.sv
`timescale 1ns / 1ps

module positional_list_engine_top_tb;

  localparam int LIST_CAP       = 64;
  localparam int RAND_ITEMS     = 1600;
  localparam int CALM_ITEMS     = 150;
  localparam int HOLD_AT        = 500;
  localparam int PAUSE_AT       = 900;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 1500;
  localparam int DIRECTED_ROWS  = 25;

  // kind codes the block treats as no operation
  localparam logic [2:0] KIND_SPARE_A = 3'd5;
  localparam logic [2:0] KIND_SPARE_B = 3'd6;
  localparam logic [2:0] KIND_SPARE_C = 3'd7;

  typedef enum int {
    GEN_MIX,
    GEN_FILL,
    GEN_DRAIN
  } gen_mode_t;

  typedef struct packed {
    logic [31:0]      read_value;
    ple_pkg::status_t status;
    logic [6:0]       count;
    logic             is_empty;
  } list_result_t;

  typedef struct packed {
    logic [2:0]   kind;
    logic [6:0]   pos;
    logic [31:0]  value;
    bit           typed;
    list_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_kind;
  logic [6:0]  in_position;
  logic signed [31:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic signed [31:0] out_read_value;
  logic [1:0]  out_status;
  logic [6:0]  out_count;
  logic        out_is_empty;

  // mirror of the list contents
  logic [31:0] list_vals [LIST_CAP];
  int          list_len = 0;

  list_result_t pending_results [$];
  list_result_t want;
  int          mismatches = 0;
  int          stuck_cycles = 0;
  int          gap_pct = 20;
  int          stall_pct = 20;
  bit          calm = 1'b0;
  bit          hold_out = 1'b0;

  logic [31:0] extreme_vals [5] = '{32'h0000_0000, 32'h0000_0001, 32'h7fff_ffff,
                                    32'h8000_0000, 32'hffff_ffff};

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ple_pkg::KIND_GET, 7'd0, 32'h0000_0000, 1'b1, '{32'h0, ple_pkg::ST_BAD_POS, 7'd0, 1'b1}},
    '{ple_pkg::KIND_REMOVE, 7'd0, 32'h0000_0000, 1'b1, '{32'h0, ple_pkg::ST_OK, 7'd0, 1'b1}},
    '{ple_pkg::KIND_INSERT, 7'd127, 32'h1234_5678, 1'b1, '{32'h0, ple_pkg::ST_OK, 7'd0, 1'b1}},
    '{ple_pkg::KIND_INSERT, 7'd1, 32'h1234_5678, 1'b1, '{32'h0, ple_pkg::ST_OK, 7'd0, 1'b1}},
    '{ple_pkg::KIND_INSERT, 7'd0, 32'h7fff_ffff, 1'b1, '{32'h0, ple_pkg::ST_OK, 7'd1, 1'b0}},
    '{ple_pkg::KIND_INSERT, 7'd1, 32'h8000_0000, 1'b1, '{32'h0, ple_pkg::ST_OK, 7'd2, 1'b0}},
    '{ple_pkg::KIND_INSERT, 7'd0, 32'hffff_ffff, 1'b0, '0},
    '{ple_pkg::KIND_INSERT, 7'd3, 32'h0000_0000, 1'b0, '0},
    '{ple_pkg::KIND_INSERT, 7'd2, 32'h5555_5555, 1'b0, '0},
    '{ple_pkg::KIND_GET, 7'd0, 32'h0000_0000, 1'b0, '0},
    '{ple_pkg::KIND_GET, 7'd4, 32'hffff_ffff, 1'b0, '0},
    '{ple_pkg::KIND_GET, 7'd5, 32'h0000_0000, 1'b1, '{32'h0, ple_pkg::ST_BAD_POS, 7'd5, 1'b0}},
    '{ple_pkg::KIND_SET, 7'd2, 32'haaaa_aaaa, 1'b0, '0},
    '{ple_pkg::KIND_SET, 7'd127, 32'h0000_0001, 1'b1, '{32'h0, ple_pkg::ST_BAD_POS, 7'd5, 1'b0}},
    '{ple_pkg::KIND_SET, 7'd5, 32'h0000_0001, 1'b1, '{32'h0, ple_pkg::ST_BAD_POS, 7'd5, 1'b0}},
    '{ple_pkg::KIND_GET, 7'd2, 32'h0000_0000, 1'b0, '0},
    '{ple_pkg::KIND_REMOVE, 7'd0, 32'h0000_0000, 1'b0, '0},
    '{ple_pkg::KIND_REMOVE, 7'd4, 32'h0000_0000, 1'b1, '{32'h0, ple_pkg::ST_OK, 7'd4, 1'b0}},
    '{ple_pkg::KIND_REMOVE, 7'd3, 32'h0000_0000, 1'b0, '0},
    '{KIND_SPARE_A, 7'd0, 32'hffff_ffff, 1'b1, '{32'h0, ple_pkg::ST_OK, 7'd3, 1'b0}},
    '{KIND_SPARE_B, 7'd127, 32'h8000_0000, 1'b1, '{32'h0, ple_pkg::ST_OK, 7'd3, 1'b0}},
    '{KIND_SPARE_C, 7'd64, 32'h7fff_ffff, 1'b1, '{32'h0, ple_pkg::ST_OK, 7'd3, 1'b0}},
    '{ple_pkg::KIND_GET, 7'd64, 32'h0000_0000, 1'b1, '{32'h0, ple_pkg::ST_BAD_POS, 7'd3, 1'b0}},
    '{ple_pkg::KIND_CLEAR, 7'd0, 32'h0000_0000, 1'b1, '{32'h0, ple_pkg::ST_OK, 7'd0, 1'b1}},
    '{ple_pkg::KIND_CLEAR, 7'd127, 32'hffff_ffff, 1'b1, '{32'h0, ple_pkg::ST_OK, 7'd0, 1'b1}}
  };

  positional_list_engine_top #(
    .CAPACITY    (LIST_CAP),
    .VALUE_WIDTH (32)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_is_empty   (out_is_empty)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Apply one operation to the mirror and return the result it gives.
  function automatic list_result_t apply_list_op(logic [2:0] k, logic [6:0] p,
                                                 logic [31:0] v);
    list_result_t r;
    int i;
    r.read_value = '0;
    r.status     = ple_pkg::ST_OK;
    case (k)
      ple_pkg::KIND_INSERT: begin
        if (p <= list_len) begin
          if (list_len >= LIST_CAP) begin
            r.status = ple_pkg::ST_FULL;
          end else begin
            for (i = list_len; i > p; i--) list_vals[i] = list_vals[i - 1];
            list_vals[p[5:0]] = v;
            list_len++;
          end
        end
      end
      ple_pkg::KIND_REMOVE: begin
        if (p < list_len) begin
          for (i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
          list_len--;
        end
      end
      ple_pkg::KIND_SET: begin
        if (p < list_len) list_vals[p[5:0]] = v;
        else r.status = ple_pkg::ST_BAD_POS;
      end
      ple_pkg::KIND_GET: begin
        if (p < list_len) r.read_value = list_vals[p[5:0]];
        else r.status = ple_pkg::ST_BAD_POS;
      end
      ple_pkg::KIND_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count    = list_len[6:0];
    r.is_empty = (list_len == 0);
    return r;
  endfunction

  // Called right after an accept edge; returns at the edge that accepts this item.
  task automatic send_op(input logic [2:0] k, input logic [6:0] p, input logic [31:0] v,
                         input bit use_typed, input list_result_t typed_res);
    list_result_t predicted;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= k;
    in_position <= p;
    in_value    <= v;
    do @(posedge clk); while (!in_ready);
    predicted = apply_list_op(k, p, v);
    pending_results.push_back(use_typed ? typed_res : predicted);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item: expected none actual %h/%0d/%0d/%0b", $time,
                 out_read_value, out_status, out_count, out_is_empty);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_value", want.read_value, out_read_value);
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("count", 32'(want.count), 32'(out_count));
        check_field("is_empty", 32'(want.is_empty), 32'(out_is_empty));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("positional_list_engine_top_tb: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : receiver
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        // hold off long enough for the block to back up onto its input
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_out = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [2:0] k;
    logic [6:0] p;
    logic [31:0] v;
    gen_mode_t seg_mode;
    int seg_len;
    int n;
    int roll;
    int rand_sent;
    bit noise;
    bit hold_done;
    bit pause_done;

    rand_sent   = 0;
    hold_done   = 1'b0;
    pause_done  = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_kind     = ple_pkg::KIND_INSERT;
    in_position = '0;
    in_value    = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < DIRECTED_ROWS; n++) begin
      send_op(directed_rows[n].kind, directed_rows[n].pos, directed_rows[n].value,
              directed_rows[n].typed, directed_rows[n].res);
    end

    while (rand_sent < RAND_ITEMS) begin
      seg_mode  = gen_mode_t'($urandom_range(GEN_MIX, GEN_DRAIN));
      gap_pct   = $urandom_range(0, 3) * 12;
      stall_pct = $urandom_range(0, 3) * 12;
      case (seg_mode)
        GEN_FILL:  seg_len = LIST_CAP - list_len + $urandom_range(1, 6);
        GEN_DRAIN: seg_len = list_len + $urandom_range(1, 4);
        default:   seg_len = $urandom_range(20, 120);
      endcase
      for (n = 0; n < seg_len && rand_sent < RAND_ITEMS; n++) begin
        calm = (rand_sent >= RAND_ITEMS - CALM_ITEMS);
        v = ($urandom_range(0, 7) == 0) ? extreme_vals[$urandom_range(0, 4)] : $urandom;
        roll = $urandom_range(0, 99);
        case (seg_mode)
          GEN_FILL: begin
            k = ple_pkg::KIND_INSERT;
            // once full, keep pushing: good positions are refused, out-of-range ones ignored
            if (list_len < LIST_CAP || roll < 50) p = 7'($urandom_range(0, list_len));
            else p = 7'($urandom_range(0, 127));
          end
          GEN_DRAIN: begin
            if (list_len > 0) begin
              k = ple_pkg::KIND_REMOVE;
              p = 7'($urandom_range(0, list_len - 1));
            end else begin
              k = 3'($urandom_range(ple_pkg::KIND_INSERT, ple_pkg::KIND_GET));
              p = 7'($urandom_range(1, 127));
            end
          end
          default: begin
            p = (list_len == 0) ? 7'd0 : 7'($urandom_range(0, list_len - 1));
            if (roll < 30) begin
              k = ple_pkg::KIND_INSERT;
              p = 7'($urandom_range(0, list_len));
            end else if (roll < 50) begin
              k = ple_pkg::KIND_REMOVE;
            end else if (roll < 60) begin
              k = ple_pkg::KIND_SET;
            end else if (roll < 85) begin
              k = ple_pkg::KIND_GET;
            end else if (roll < 95) begin
              k = 3'($urandom_range(ple_pkg::KIND_INSERT, ple_pkg::KIND_GET));
              p = 7'($urandom_range(list_len + 1, 127));
            end else if (roll < 97) begin
              k = ple_pkg::KIND_CLEAR;
              p = 7'($urandom_range(0, 127));
            end else begin
              k = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
              p = 7'($urandom_range(0, 127));
            end
          end
        endcase
        noise = (k == ple_pkg::KIND_INSERT && p > list_len) ||
                (k == ple_pkg::KIND_REMOVE && p >= list_len) ||
                (k > ple_pkg::KIND_CLEAR);
        send_op(k, p, v, 1'b0, '0);
        if (!noise) rand_sent++;
        if (!hold_done && rand_sent >= HOLD_AT) begin
          hold_done = 1'b1;
          hold_out  = 1'b1;
        end
        if (!pause_done && rand_sent >= PAUSE_AT) begin
          pause_done = 1'b1;
          @(negedge clk);
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("positional_list_engine_top_tb: clean");
    end else begin
      $display("positional_list_engine_top_tb: errors");
    end
    $finish;
  end

endmodule
